/* rtl/mspc_pkg.sv */
package mspc_pkg;

    // field widths
    localparam int RAW_W       = 16;
    localparam int TARGET_W    = 24;
    localparam int TARGET_FRAC = 8;
    localparam int TOTAL_W     = 20;
    localparam int ERR_W       = 26;
    localparam int ACC_W       = 48;
    localparam int FRAC_SHIFT  = 12;
    localparam int TRAVEL_W    = 40;
    localparam int DRIVE_W     = 17;
    localparam int DUTY_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int GOAL_W      = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    localparam int WINDOW_LEN_DEFAULT = 5;

    // pipeline stages
    localparam int NUM_STAGES = 8;
    localparam int ST_INPUT   = 0;
    localparam int ST_TOTAL   = 1;
    localparam int ST_AVG     = 2;
    localparam int ST_ERR     = 3;
    localparam int ST_PROD    = 4;
    localparam int ST_ACC     = 5;
    localparam int ST_SUM     = 6;
    localparam int ST_OUT     = 7;

    localparam logic [GAIN_W-1:0]         GAIN_PROP_RESET     = 16'd4800;
    localparam logic [GAIN_W-1:0]         GAIN_INTEGRAL_RESET = 16'd480;
    localparam logic [DUTY_W-1:0]         DUTY_UPPER_RESET    = 16'd10000;
    localparam logic signed [DRIVE_W-1:0] DUTY_LOWER_RESET    = -17'sd10000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_PROP     = 3'd0,
        REG_GAIN_INTEGRAL = 3'd1,
        REG_DUTY_UPPER    = 3'd2,
        REG_DUTY_LOWER    = 3'd3,
        REG_DRIVE_ENABLE  = 3'd4,
        REG_DISTANCE_GOAL = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [GAIN_W-1:0]         gain_prop;
        logic [GAIN_W-1:0]         gain_integral;
        logic [DUTY_W-1:0]         duty_upper;
        logic signed [DRIVE_W-1:0] duty_lower;
        logic                      drive_enable;
        logic [GOAL_W-1:0]         distance_goal;
    } cfg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic                  in_ready;
        logic                  out_valid;
    } flow_t;

    typedef struct packed {
        logic signed [RAW_W-1:0]    avg;
        logic signed [TARGET_W-1:0] target;
        logic                       reached;
    } win_out_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_signed;
        logic                      drive_reverse;
        logic [DUTY_W-1:0]         duty_magnitude;
        logic                      drive_valid;
        logic signed [RAW_W-1:0]   average_rate;
        logic                      distance_reached;
    } result_t;

endpackage

/* rtl/mspc_channels.sv */
interface mspc_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mspc_pkg::RAW_W-1:0]    encoder_raw;
    logic signed [mspc_pkg::TARGET_W-1:0] target_rate;

    modport source (output valid, output encoder_raw, output target_rate, input ready);
    modport sink   (input valid, input encoder_raw, input target_rate, output ready);
endinterface

interface mspc_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [mspc_pkg::DRIVE_W-1:0] drive_signed;
    logic                                drive_reverse;
    logic [mspc_pkg::DUTY_W-1:0]         duty_magnitude;
    logic                                drive_valid;
    logic signed [mspc_pkg::RAW_W-1:0]   average_rate;
    logic                                distance_reached;

    modport source (output valid, output drive_signed, output drive_reverse,
                    output duty_magnitude, output drive_valid, output average_rate,
                    output distance_reached, input ready);
    modport sink   (input valid, input drive_signed, input drive_reverse,
                    input duty_magnitude, input drive_valid, input average_rate,
                    input distance_reached, output ready);
endinterface

interface mspc_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [mspc_pkg::CFG_INDEX_W-1:0]      index;
    logic [mspc_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/mspc_cfg_regs.sv */
module mspc_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    mspc_cfg_if.sink       cfg,
    output mspc_pkg::cfg_t regs
);

    mspc_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop     <= mspc_pkg::GAIN_PROP_RESET;
            cfg_reg.gain_integral <= mspc_pkg::GAIN_INTEGRAL_RESET;
            cfg_reg.duty_upper    <= mspc_pkg::DUTY_UPPER_RESET;
            cfg_reg.duty_lower    <= mspc_pkg::DUTY_LOWER_RESET;
            cfg_reg.drive_enable  <= 1'b0;
            cfg_reg.distance_goal <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                mspc_pkg::REG_GAIN_PROP:
                    cfg_reg.gain_prop <= cfg.data[mspc_pkg::GAIN_W-1:0];
                mspc_pkg::REG_GAIN_INTEGRAL:
                    cfg_reg.gain_integral <= cfg.data[mspc_pkg::GAIN_W-1:0];
                mspc_pkg::REG_DUTY_UPPER:
                    cfg_reg.duty_upper <= cfg.data[mspc_pkg::DUTY_W-1:0];
                mspc_pkg::REG_DUTY_LOWER:
                    cfg_reg.duty_lower <= cfg.data[mspc_pkg::DRIVE_W-1:0];
                mspc_pkg::REG_DRIVE_ENABLE:
                    cfg_reg.drive_enable <= cfg.data[0];
                mspc_pkg::REG_DISTANCE_GOAL:
                    cfg_reg.distance_goal <= cfg.data[mspc_pkg::GOAL_W-1:0];
                default:
                    ; // unknown index: drop the write
            endcase
        end
    end

endmodule

/* rtl/mspc_flow_ctrl.sv */
module mspc_flow_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    input  logic            result_ready,
    output mspc_pkg::flow_t flow
);

    localparam int N = mspc_pkg::NUM_STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] free;
    logic [N-1:0] load;
    logic [N-1:0] upstream;
    logic         down;

    assign upstream = {valid_reg[N-2:0], sample_valid};

    // walk from the output back: a stage takes a word when it is empty or its word moves on
    always_comb
    begin
        free = '0;
        load = '0;
        down = result_ready;
        for (int k = N - 1; k >= 0; k--)
        begin
            free[k] = !valid_reg[k] || down;
            load[k] = upstream[k] && free[k];
            down    = load[k];
        end
        valid_next = load | (valid_reg & ~free);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign flow.load      = load;
    assign flow.in_ready  = free[0];
    assign flow.out_valid = valid_reg[N-1];

    a_occupancy_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(valid_reg) <= $past($countones(valid_reg)) + 1)
        else $error("pipeline occupancy grew by more than one word");

    a_occupancy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !load[0] && !(valid_reg[N-1] && result_ready)
        |=> $countones(valid_reg) == $past($countones(valid_reg)))
        else $error("pipeline word lost or invented");

endmodule

/* rtl/mspc_window.sv */
module mspc_window #(
    parameter int WINDOW_LEN = mspc_pkg::WINDOW_LEN_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mspc_pkg::flow_t                      flow,
    input  mspc_pkg::cfg_t                       regs,
    input  logic signed [mspc_pkg::RAW_W-1:0]    encoder_raw,
    input  logic signed [mspc_pkg::TARGET_W-1:0] target_rate,
    output mspc_pkg::win_out_t                   win
);

    localparam int RAW_W    = mspc_pkg::RAW_W;
    localparam int TARGET_W = mspc_pkg::TARGET_W;
    localparam int TOTAL_W  = mspc_pkg::TOTAL_W;
    localparam int TRAVEL_W = mspc_pkg::TRAVEL_W;
    localparam int TSUM_W   = TRAVEL_W + 1;

    // exact floor division of the window magnitude by a reciprocal multiply
    localparam int DIV_SHIFT = TOTAL_W + $clog2(WINDOW_LEN);
    localparam int MUL_W     = TOTAL_W + 1;
    localparam int PROD_W    = TOTAL_W + MUL_W;
    localparam int QUOT_W    = RAW_W + 1;
    localparam logic [MUL_W-1:0] DIV_MUL =
        MUL_W'(((1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);
    localparam int GOAL_SCALED_W = mspc_pkg::GOAL_W + $clog2(WINDOW_LEN) + 1;

    logic signed [RAW_W-1:0]    s0_raw_reg;
    logic signed [TARGET_W-1:0] s0_target_reg;
    logic signed [TARGET_W-1:0] s1_target_reg;
    logic signed [RAW_W-1:0]    hist_reg [WINDOW_LEN];
    logic signed [TOTAL_W-1:0]  window_total_reg;
    logic signed [TRAVEL_W-1:0] travel_reg;
    logic                       reached_reg;
    mspc_pkg::win_out_t         win_reg;

    logic signed [RAW_W-1:0]     raw_neg;
    logic signed [TOTAL_W-1:0]   total_next;
    logic [TOTAL_W-1:0]          total_mag;
    logic [PROD_W-1:0]           quot_prod;
    logic [QUOT_W-1:0]           quot;
    logic [QUOT_W-1:0]           quot_neg;
    logic signed [RAW_W-1:0]     avg_next;
    logic signed [TSUM_W-1:0]    travel_sum;
    logic signed [TRAVEL_W-1:0]  travel_next;
    logic [GOAL_SCALED_W-1:0]    goal_scaled;
    logic                        reached_next;
    logic                        goal_set;

    assign raw_neg    = -s0_raw_reg;
    assign total_next = window_total_reg + TOTAL_W'(raw_neg)
                        - TOTAL_W'(hist_reg[WINDOW_LEN-1]);

    assign total_mag = window_total_reg[TOTAL_W-1] ? -window_total_reg : window_total_reg;
    assign quot_prod = total_mag * DIV_MUL;
    assign quot      = quot_prod[DIV_SHIFT +: QUOT_W];
    assign quot_neg  = -quot;
    assign avg_next  = window_total_reg[TOTAL_W-1] ? quot_neg[RAW_W-1:0] : quot[RAW_W-1:0];

    assign travel_sum = TSUM_W'(travel_reg) + TSUM_W'(window_total_reg);

    always_comb
    begin
        if (travel_sum[TSUM_W-1] != travel_sum[TSUM_W-2])
            travel_next = travel_sum[TSUM_W-1] ? {1'b1, {(TRAVEL_W-1){1'b0}}}
                                               : {1'b0, {(TRAVEL_W-1){1'b1}}};
        else
            travel_next = travel_sum[TRAVEL_W-1:0];
    end

    assign goal_set     = regs.distance_goal != '0;
    assign goal_scaled  = GOAL_SCALED_W'(regs.distance_goal * WINDOW_LEN);
    assign reached_next = !travel_next[TRAVEL_W-1]
                          && (travel_next[TRAVEL_W-2:0] > (TRAVEL_W-1)'(goal_scaled));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
                hist_reg[i] <= '0;
            window_total_reg <= '0;
            travel_reg       <= '0;
            reached_reg      <= 1'b0;
        end
        else
        begin
            if (flow.load[mspc_pkg::ST_TOTAL])
            begin
                for (int i = WINDOW_LEN - 1; i > 0; i--)
                    hist_reg[i] <= hist_reg[i-1];
                hist_reg[0]      <= raw_neg;
                window_total_reg <= total_next;
            end
            if (flow.load[mspc_pkg::ST_AVG] && goal_set)
            begin
                travel_reg  <= travel_next;
                reached_reg <= reached_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.load[mspc_pkg::ST_INPUT])
        begin
            s0_raw_reg    <= encoder_raw;
            s0_target_reg <= target_rate;
        end
        if (flow.load[mspc_pkg::ST_TOTAL])
            s1_target_reg <= s0_target_reg;
        if (flow.load[mspc_pkg::ST_AVG])
        begin
            win_reg.avg     <= avg_next;
            win_reg.target  <= s1_target_reg;
            win_reg.reached <= goal_set ? reached_next : reached_reg;
        end
    end

    assign win = win_reg;

    a_goal_off_holds: assert property (@(posedge clk) disable iff (!rst_n)
        flow.load[mspc_pkg::ST_AVG] && !goal_set |=> $stable(travel_reg) && $stable(reached_reg))
        else $error("travel changed while distance tracking is off");

    a_reached_follows: assert property (@(posedge clk) disable iff (!rst_n)
        flow.load[mspc_pkg::ST_AVG] |=> win_reg.reached == reached_reg)
        else $error("reached flag in word differs from tracked flag");

endmodule

/* rtl/mspc_pi_law.sv */
module mspc_pi_law (
    input  logic                clk,
    input  logic                rst_n,
    input  mspc_pkg::flow_t     flow,
    input  mspc_pkg::cfg_t      regs,
    input  mspc_pkg::win_out_t  win,
    output mspc_pkg::result_t   res
);

    localparam int RAW_W      = mspc_pkg::RAW_W;
    localparam int ERR_W      = mspc_pkg::ERR_W;
    localparam int DELTA_W    = ERR_W + 1;
    localparam int GAIN_X_W   = mspc_pkg::GAIN_W + 1;
    localparam int PP_W       = GAIN_X_W + DELTA_W;
    localparam int IP_W       = GAIN_X_W + ERR_W;
    localparam int ACC_W      = mspc_pkg::ACC_W;
    localparam int SUM_W      = ACC_W + 1;
    localparam int FRAC_SHIFT = mspc_pkg::FRAC_SHIFT;
    localparam int QW         = SUM_W - FRAC_SHIFT;
    localparam int DRIVE_W    = mspc_pkg::DRIVE_W;
    localparam int DUTY_W     = mspc_pkg::DUTY_W;

    typedef struct packed {
        logic signed [RAW_W-1:0] avg;
        logic                    reached;
    } tag_t;

    tag_t                      tag_reg [mspc_pkg::ST_ERR:mspc_pkg::ST_SUM];
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic signed [PP_W-1:0]    pp_reg;
    logic signed [IP_W-1:0]    ip_reg;
    logic signed [ACC_W-1:0]   prop_reg;
    logic signed [ACC_W-1:0]   integ_reg;
    logic signed [QW-1:0]      q_reg;
    mspc_pkg::result_t         res_reg;

    logic signed [ERR_W-1:0]   err_next;
    logic signed [DELTA_W-1:0] delta_next;
    logic signed [PP_W-1:0]    pp_next;
    logic signed [IP_W-1:0]    ip_next;
    logic signed [SUM_W-1:0]   prop_sum;
    logic signed [ACC_W-1:0]   prop_next;
    logic signed [SUM_W-1:0]   integ_sum;
    logic signed [SUM_W-1:0]   hi_lim;
    logic signed [SUM_W-1:0]   lo_lim;
    logic signed [ACC_W-1:0]   integ_next;
    logic signed [SUM_W-1:0]   drive_sum;
    logic                      round_up;
    logic signed [QW-1:0]      q_next;
    logic signed [QW-1:0]      upper_x;
    logic signed [QW-1:0]      lower_x;
    logic signed [DRIVE_W-1:0] drive_next;
    logic [DRIVE_W-1:0]        mag_full;
    logic [DUTY_W-1:0]         mag_next;

    // error and its change
    assign err_next   = ERR_W'($signed(win.target))
                        - (ERR_W'($signed(win.avg)) <<< mspc_pkg::TARGET_FRAC);
    assign delta_next = DELTA_W'(err_next) - DELTA_W'(prev_err_reg);

    // gain products
    assign pp_next = $signed({1'b0, regs.gain_prop}) * delta_reg;
    assign ip_next = $signed({1'b0, regs.gain_integral}) * err_reg;

    // accumulators: saturate the proportional one, clamp the integral one
    assign prop_sum  = SUM_W'(prop_reg) + SUM_W'(pp_reg);
    assign integ_sum = SUM_W'(integ_reg) + SUM_W'(ip_reg);
    assign hi_lim    = SUM_W'($signed({1'b0, regs.duty_upper, {FRAC_SHIFT{1'b0}}}));
    assign lo_lim    = SUM_W'($signed({regs.duty_lower, {FRAC_SHIFT{1'b0}}}));

    always_comb
    begin
        if (prop_sum[SUM_W-1] != prop_sum[SUM_W-2])
            prop_next = prop_sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                          : {1'b0, {(ACC_W-1){1'b1}}};
        else
            prop_next = prop_sum[ACC_W-1:0];

        if (integ_sum > hi_lim)
            integ_next = hi_lim[ACC_W-1:0];
        else if (integ_sum < lo_lim)
            integ_next = lo_lim[ACC_W-1:0];
        else
            integ_next = integ_sum[ACC_W-1:0];
    end

    // drop the fraction, rounding toward zero
    assign drive_sum = SUM_W'(prop_reg) + SUM_W'(integ_reg);
    assign round_up  = drive_sum[SUM_W-1] && (|drive_sum[FRAC_SHIFT-1:0]);
    assign q_next    = $signed(drive_sum[SUM_W-1:FRAC_SHIFT]) + $signed({{(QW-1){1'b0}}, round_up});

    // limits, upper test first, then split into direction and duty
    assign upper_x = QW'($signed({1'b0, regs.duty_upper}));
    assign lower_x = QW'(regs.duty_lower);

    always_comb
    begin
        if (q_reg > upper_x)
            drive_next = $signed({1'b0, regs.duty_upper});
        else if (q_reg < lower_x)
            drive_next = regs.duty_lower;
        else
            drive_next = q_reg[DRIVE_W-1:0];

        mag_full = -drive_next;
        if (!drive_next[DRIVE_W-1])
            mag_next = drive_next[DUTY_W-1:0];
        else if (mag_full[DRIVE_W-1])
            mag_next = '1;
        else
            mag_next = mag_full[DUTY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            prop_reg     <= '0;
            integ_reg    <= '0;
        end
        else
        begin
            if (flow.load[mspc_pkg::ST_ERR])
                prev_err_reg <= err_next;
            if (flow.load[mspc_pkg::ST_ACC])
            begin
                prop_reg  <= prop_next;
                integ_reg <= integ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.load[mspc_pkg::ST_ERR])
        begin
            tag_reg[mspc_pkg::ST_ERR].avg     <= win.avg;
            tag_reg[mspc_pkg::ST_ERR].reached <= win.reached;
            err_reg   <= err_next;
            delta_reg <= delta_next;
        end
        for (int k = mspc_pkg::ST_PROD; k <= mspc_pkg::ST_SUM; k++)
        begin
            if (flow.load[k])
                tag_reg[k] <= tag_reg[k-1];
        end
        if (flow.load[mspc_pkg::ST_PROD])
        begin
            pp_reg <= pp_next;
            ip_reg <= ip_next;
        end
        if (flow.load[mspc_pkg::ST_SUM])
            q_reg <= q_next;
        if (flow.load[mspc_pkg::ST_OUT])
        begin
            res_reg.drive_signed     <= drive_next;
            res_reg.drive_reverse    <= drive_next[DRIVE_W-1];
            res_reg.duty_magnitude   <= mag_next;
            res_reg.drive_valid      <= regs.drive_enable;
            res_reg.average_rate     <= tag_reg[mspc_pkg::ST_SUM].avg;
            res_reg.distance_reached <= tag_reg[mspc_pkg::ST_SUM].reached;
        end
    end

    assign res = res_reg;

    a_integ_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        flow.load[mspc_pkg::ST_ACC] && (regs.duty_lower <= $signed({1'b0, regs.duty_upper}))
        |=> (SUM_W'(integ_reg) <= $past(hi_lim)) && (SUM_W'(integ_reg) >= $past(lo_lim)))
        else $error("integral accumulator outside drive limits");

    a_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        flow.load[mspc_pkg::ST_OUT]
        |=> (res_reg.duty_magnitude == '0) == (res_reg.drive_signed == '0))
        else $error("duty magnitude disagrees with drive value");

endmodule

/* rtl/motor_speed_pi_controller_unit.sv */
// Speed loop for one DC motor: each sample word (raw encoder count, Q.8 target rate) gives one
// result word with the clamped signed drive, its direction and duty, the window average of the
// inverted counts and the distance-reached flag. The datapath is an eight stage pipeline (input,
// window total, average, error, gain products, accumulators, fraction drop, limits); one word per
// cycle is accepted when the result side keeps up. Registers are written through the configuration
// channel, which is always ready; write them only while no sample word is in flight. The valid
// flags, window history, accumulators and configuration registers clear at reset; the data word
// registers do not.
module motor_speed_pi_controller_unit #(
    parameter int WINDOW_LEN = mspc_pkg::WINDOW_LEN_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    mspc_sample_if.sink   sample,
    mspc_result_if.source result,
    mspc_cfg_if.sink      cfg
);

    mspc_pkg::cfg_t     regs;
    mspc_pkg::flow_t    flow;
    mspc_pkg::win_out_t win;
    mspc_pkg::result_t  res;

    mspc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mspc_flow_ctrl u_flow_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .result_ready (result.ready),
        .flow         (flow)
    );

    mspc_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .flow        (flow),
        .regs        (regs),
        .encoder_raw (sample.encoder_raw),
        .target_rate (sample.target_rate),
        .win         (win)
    );

    mspc_pi_law u_pi_law (
        .clk   (clk),
        .rst_n (rst_n),
        .flow  (flow),
        .regs  (regs),
        .win   (win),
        .res   (res)
    );

    assign sample.ready            = flow.in_ready;
    assign result.valid            = flow.out_valid;
    assign result.drive_signed     = res.drive_signed;
    assign result.drive_reverse    = res.drive_reverse;
    assign result.duty_magnitude   = res.duty_magnitude;
    assign result.drive_valid      = res.drive_valid;
    assign result.average_rate     = res.average_rate;
    assign result.distance_reached = res.distance_reached;

endmodule

/* tb/sv/tb_motor_speed_pi_controller_unit.sv */
`timescale 1ns / 1ps

module tb_motor_speed_pi_controller_unit;

    localparam int     RAW_W        = mspc_pkg::RAW_W;
    localparam int     TARGET_W     = mspc_pkg::TARGET_W;
    localparam int     GAIN_W       = mspc_pkg::GAIN_W;
    localparam int     DUTY_W       = mspc_pkg::DUTY_W;
    localparam int     DRIVE_W      = mspc_pkg::DRIVE_W;
    localparam int     GOAL_W       = mspc_pkg::GOAL_W;
    localparam int     CFG_INDEX_W  = mspc_pkg::CFG_INDEX_W;

    localparam int     WINDOW_LEN   = mspc_pkg::WINDOW_LEN_DEFAULT;
    localparam int     CLK_HALF     = 6;
    localparam int     RESET_CYCLES = 10;
    localparam int     LONG_HOLD    = 300;
    localparam int     PHASE_ITEMS  = 250;
    localparam int     RANDOM_PHASES = 8;
    localparam longint TIMEOUT_NS   = 20_000_000;

    localparam longint ACC_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN    = -ACC_MAX - 1;
    localparam longint TRAVEL_MAX = 64'sh0000_007F_FFFF_FFFF;
    localparam longint TRAVEL_MIN = -TRAVEL_MAX - 1;
    localparam longint ACC_ONE    = longint'(1) << mspc_pkg::FRAC_SHIFT;
    localparam longint DUTY_FULL  = 65535;

    // indexes the block has no register for
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    typedef mspc_pkg::result_t result_t;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_e;

    typedef struct packed {
        logic signed [RAW_W-1:0]    encoder;
        logic signed [TARGET_W-1:0] target;
    } sample_t;

    logic clk = 1'b0;
    logic rst_n;

    mspc_sample_if sample_ch();
    mspc_result_if result_ch();
    mspc_cfg_if    cfg_ch();

    motor_speed_pi_controller_unit #(
        .WINDOW_LEN(WINDOW_LEN)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .cfg   (cfg_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    // speed loop state as the block should hold it
    logic signed [RAW_W-1:0]   count_window [WINDOW_LEN] = '{default: '0};
    longint                    prev_err_q8 = 0;
    longint                    prop_acc    = 0;
    longint                    integ_acc   = 0;
    longint                    travel_acc  = 0;
    logic                      goal_passed = 1'b0;
    logic [GAIN_W-1:0]         kp_q4       = mspc_pkg::GAIN_PROP_RESET;
    logic [GAIN_W-1:0]         ki_q4       = mspc_pkg::GAIN_INTEGRAL_RESET;
    logic [DUTY_W-1:0]         duty_hi     = mspc_pkg::DUTY_UPPER_RESET;
    logic signed [DRIVE_W-1:0] duty_lo     = mspc_pkg::DUTY_LOWER_RESET;
    logic                      drive_en    = 1'b0;
    logic [GOAL_W-1:0]         travel_goal = '0;

    sample_t    sample_pending_q [$];
    result_t    drive_expect_q [$];
    int         queued_count   = 0;
    int         accepted_count = 0;
    int         mismatch_count = 0;
    int         cruise_speed   = 0;
    idle_mode_e src_mode       = IDLE_LIGHT;
    idle_mode_e sink_mode      = IDLE_LIGHT;
    int         holds_wanted   = 0;

    function automatic result_t compute_drive(input logic signed [RAW_W-1:0] encoder,
                                              input logic signed [TARGET_W-1:0] target);
        logic signed [RAW_W-1:0] inverted;
        longint window_sum, avg, err, hi, lo, drive, mag;
        result_t r;
        inverted = -encoder;
        for (int i = WINDOW_LEN - 1; i > 0; i--)
            count_window[i] = count_window[i-1];
        count_window[0] = inverted;
        window_sum = 0;
        for (int i = 0; i < WINDOW_LEN; i++)
            window_sum += longint'(count_window[i]);
        avg = window_sum / WINDOW_LEN;
        err = longint'(target) - avg * 256;

        prop_acc = prop_acc + longint'(kp_q4) * (err - prev_err_q8);
        if (prop_acc > ACC_MAX)
            prop_acc = ACC_MAX;
        else if (prop_acc < ACC_MIN)
            prop_acc = ACC_MIN;

        // integral clamp follows the drive limits, upper test first
        hi = longint'(duty_hi) * ACC_ONE;
        lo = longint'(duty_lo) * ACC_ONE;
        integ_acc = integ_acc + longint'(ki_q4) * err;
        if (integ_acc > hi)
            integ_acc = hi;
        else if (integ_acc < lo)
            integ_acc = lo;

        drive = (prop_acc + integ_acc) / ACC_ONE;
        if (drive > longint'(duty_hi))
            drive = longint'(duty_hi);
        else if (drive < longint'(duty_lo))
            drive = longint'(duty_lo);
        prev_err_q8 = err;

        if (travel_goal != '0)
        begin
            travel_acc = travel_acc + window_sum;
            if (travel_acc > TRAVEL_MAX)
                travel_acc = TRAVEL_MAX;
            else if (travel_acc < TRAVEL_MIN)
                travel_acc = TRAVEL_MIN;
            goal_passed = travel_acc > longint'(travel_goal) * WINDOW_LEN;
        end

        mag = (drive < 0) ? -drive : drive;
        if (mag > DUTY_FULL)
            mag = DUTY_FULL;

        r.drive_signed     = drive[DRIVE_W-1:0];
        r.drive_reverse    = drive < 0;
        r.duty_magnitude   = mag[DUTY_W-1:0];
        r.drive_valid      = drive_en;
        r.average_rate     = avg[RAW_W-1:0];
        r.distance_reached = goal_passed;
        return r;
    endfunction

    function automatic int pick_gap(input idle_mode_e mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            IDLE_LIGHT:
                return (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3)
                                                     : $urandom_range(8, 40);
            IDLE_HEAVY:
                return (roll < 30) ? 0 : (roll < 85) ? $urandom_range(1, 6)
                                                     : $urandom_range(10, 60);
            default:
                return 0;
        endcase
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    // sample driver: advance to the next word once the current one is taken
    int src_gap;
    always @(posedge clk or negedge rst_n)
    begin : drive_samples
        sample_t next_word;
        if (!rst_n)
        begin
            sample_ch.valid       <= 1'b0;
            sample_ch.encoder_raw <= '0;
            sample_ch.target_rate <= '0;
            src_gap <= 0;
        end
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            if (src_gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                src_gap <= src_gap - 1;
            end
            else if (sample_pending_q.size() > 0)
            begin
                next_word = sample_pending_q.pop_front();
                sample_ch.valid       <= 1'b1;
                sample_ch.encoder_raw <= next_word.encoder;
                sample_ch.target_rate <= next_word.target;
                src_gap <= pick_gap(src_mode);
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : predict_samples
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            drive_expect_q.push_back(compute_drive(sample_ch.encoder_raw,
                                                   sample_ch.target_rate));
            accepted_count++;
        end
    end

    always @(posedge clk)
    begin : track_registers
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                mspc_pkg::REG_GAIN_PROP:     kp_q4       = cfg_ch.data[GAIN_W-1:0];
                mspc_pkg::REG_GAIN_INTEGRAL: ki_q4       = cfg_ch.data[GAIN_W-1:0];
                mspc_pkg::REG_DUTY_UPPER:    duty_hi     = cfg_ch.data[DUTY_W-1:0];
                mspc_pkg::REG_DUTY_LOWER:    duty_lo     = signed'(cfg_ch.data[DRIVE_W-1:0]);
                mspc_pkg::REG_DRIVE_ENABLE:  drive_en    = cfg_ch.data[0];
                mspc_pkg::REG_DISTANCE_GOAL: travel_goal = cfg_ch.data[GOAL_W-1:0];
                default: ;
            endcase
        end
    end

    // long receiver hold-off: start one per request, count it down
    int hold_left;
    int holds_started;
    always @(posedge clk or negedge rst_n)
    begin : hold_receiver
        if (!rst_n)
        begin
            hold_left <= 0;
            holds_started <= 0;
        end
        else if (holds_started != holds_wanted)
        begin
            holds_started <= holds_wanted;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // result monitor and ready generator
    int sink_gap;
    always @(posedge clk or negedge rst_n)
    begin : collect_results
        result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    $error("result word arrived with no prediction pending");
                    mismatch_count++;
                end
                else
                begin
                    want = drive_expect_q.pop_front();
                    check_field("drive_signed", want.drive_signed, result_ch.drive_signed);
                    check_field("drive_reverse", want.drive_reverse, result_ch.drive_reverse);
                    check_field("duty_magnitude", want.duty_magnitude,
                                result_ch.duty_magnitude);
                    check_field("drive_valid", want.drive_valid, result_ch.drive_valid);
                    check_field("average_rate", want.average_rate, result_ch.average_rate);
                    check_field("distance_reached", want.distance_reached,
                                result_ch.distance_reached);
                end
            end
            if (hold_left > 0)
                result_ch.ready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                sink_gap <= pick_gap(sink_mode);
            end
        end
    end

    // call at a clock edge; drops valid again before returning after each write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_sample(input int encoder, input int target);
        sample_t s;
        s.encoder = RAW_W'(encoder);
        s.target  = TARGET_W'(target);
        sample_pending_q.push_back(s);
        queued_count++;
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || drive_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // mostly a drifting cruise speed with a target near it, some raw noise
    task automatic queue_random_sample();
        int speed;
        if ($urandom_range(0, 9) < 2)
            queue_sample(int'($urandom), int'($urandom));
        else
        begin
            if ($urandom_range(0, 39) == 0)
                cruise_speed = int'($urandom_range(0, 60000)) - 30000;
            else
                cruise_speed += int'($urandom_range(0, 4)) - 2;
            if (cruise_speed > 30000)
                cruise_speed = 30000;
            else if (cruise_speed < -30000)
                cruise_speed = -30000;
            speed = cruise_speed + int'($urandom_range(0, 6)) - 3;
            queue_sample(-speed, cruise_speed * 256 + int'($urandom_range(0, 1023)) - 512);
        end
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return GAIN_W'($urandom_range(1000, 8000));
            4, 5, 6: return GAIN_W'($urandom_range(1, 256));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    task automatic randomize_registers();
        logic [DUTY_W-1:0]  upper;
        logic [DRIVE_W-1:0] lower;
        logic [GOAL_W-1:0]  goal;
        case ($urandom_range(0, 5))
            0:       upper = '0;
            1:       upper = '1;
            2:       upper = mspc_pkg::DUTY_UPPER_RESET;
            default: upper = DUTY_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       lower = {1'b1, {(DRIVE_W-1){1'b0}}};
            1:       lower = '0;
            2:       lower = DRIVE_W'($urandom_range(1, 65535));
            3:       lower = mspc_pkg::DUTY_LOWER_RESET;
            default: lower = DRIVE_W'(-int'($urandom_range(1, 65535)));
        endcase
        case ($urandom_range(0, 6))
            0, 1:    goal = '0;
            2:       goal = '1;
            3, 4:    goal = GOAL_W'($urandom_range(1, 3000));
            default: goal = GOAL_W'($urandom);
        endcase
        write_reg(mspc_pkg::REG_GAIN_PROP, 24'(pick_gain()));
        write_reg(mspc_pkg::REG_GAIN_INTEGRAL, 24'(pick_gain()));
        write_reg(mspc_pkg::REG_DUTY_UPPER, 24'(upper));
        write_reg(mspc_pkg::REG_DUTY_LOWER, 24'(lower));
        write_reg(mspc_pkg::REG_DRIVE_ENABLE, 24'($urandom_range(0, 1)));
        write_reg(mspc_pkg::REG_DISTANCE_GOAL, 24'(goal));
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 24'($urandom));
    endtask

    initial
    begin : run_test
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        rst_n                 = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: drive disabled, no distance goal; most negative count wraps
        queue_sample(0, 0);
        queue_sample(-32768, 0);
        queue_sample(32767, 8388607);
        queue_sample(-32768, -8388608);
        queue_sample(1, 255);
        queue_sample(-1, -256);
        wait_idle();

        // widest limits and gains; drive full reverse until the duty saturates
        write_reg(mspc_pkg::REG_GAIN_PROP, 24'hFFFF);
        write_reg(mspc_pkg::REG_GAIN_INTEGRAL, 24'hFFFF);
        write_reg(mspc_pkg::REG_DUTY_UPPER, 24'hFFFF);
        write_reg(mspc_pkg::REG_DUTY_LOWER, 24'h010000);
        write_reg(mspc_pkg::REG_DRIVE_ENABLE, 24'd1);
        write_reg(mspc_pkg::REG_DISTANCE_GOAL, 24'd1);
        write_reg(REG_SPARE_A, 24'hFFFFFF);
        write_reg(REG_SPARE_B, 24'hFFFFFF);
        repeat (3) queue_sample(-32767, -8388608);
        repeat (2) queue_sample(32767, 8388607);
        queue_sample(0, 0);
        wait_idle();

        // crossed limits: lower above upper, drive disabled, largest goal
        write_reg(mspc_pkg::REG_GAIN_PROP, 24'd16);
        write_reg(mspc_pkg::REG_GAIN_INTEGRAL, 24'd0);
        write_reg(mspc_pkg::REG_DUTY_UPPER, 24'd0);
        write_reg(mspc_pkg::REG_DUTY_LOWER, 24'h00FFFF);
        write_reg(mspc_pkg::REG_DRIVE_ENABLE, 24'd0);
        write_reg(mspc_pkg::REG_DISTANCE_GOAL, 24'hFFFFFF);
        queue_sample(100, 25600);
        queue_sample(-100, -25600);
        queue_sample(0, 0);
        queue_sample(32767, 0);
        queue_sample(-32768, 8388607);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            randomize_registers();
            case (phase)
                0:
                begin
                    src_mode  = IDLE_NONE;
                    sink_mode = IDLE_NONE;
                end
                1:
                begin
                    src_mode  = IDLE_HEAVY;
                    sink_mode = IDLE_LIGHT;
                end
                3:
                begin
                    // sender keeps offering while the receiver holds off
                    src_mode  = IDLE_NONE;
                    sink_mode = IDLE_LIGHT;
                end
                default:
                begin
                    src_mode  = idle_mode_e'($urandom_range(0, 2));
                    sink_mode = idle_mode_e'($urandom_range(0, 2));
                end
            endcase
            repeat (PHASE_ITEMS) queue_random_sample();
            if (phase == 3)
                holds_wanted++;
            wait_idle();
        end

        repeat (2 * mspc_pkg::NUM_STAGES) @(posedge clk);
        if (mismatch_count == 0 && drive_expect_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
